[design/rwar_pkg.sv]
// Shared types and constants for the reorder window ACK receiver.
// Holds packet and result layouts, command and result kind codes, and cell control types.
// Depends on nothing; every other design file refers to it by scoped names.
package rwar_pkg;

	localparam int DEF_WINDOW_DEPTH = 32;
	localparam int MAX_PAYLOAD      = 1012;

	// Packet type codes on the command field.
	localparam logic [2:0] CMD_QUERY   = 3'd0;
	localparam logic [2:0] CMD_ACK     = 3'd1;
	localparam logic [2:0] CMD_DATA    = 3'd2;
	localparam logic [2:0] CMD_FIN     = 3'd3;
	localparam logic [2:0] CMD_FIN_ACK = 3'd4;
	localparam logic [2:0] CMD_BAD     = 3'd5;
	localparam logic [2:0] CMD_MSG     = 3'd6;

	// Result kind codes.
	localparam logic [2:0] KIND_ACK     = 3'd0;
	localparam logic [2:0] KIND_FIN_ACK = 3'd1;
	localparam logic [2:0] KIND_MISSING = 3'd2;
	localparam logic [2:0] KIND_SIZE    = 3'd3;
	localparam logic [2:0] KIND_UNEXP   = 3'd4;
	localparam logic [2:0] KIND_FULL    = 3'd5;
	localparam logic [2:0] KIND_IGNORED = 3'd6;

	typedef struct packed {
		logic [2:0]  command;
		logic [31:0] seq_offset;
		logic [9:0]  payload_len;
		logic [7:0]  buffer_tag;
	} item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] ack_number;
		logic        deliver;
		logic [7:0]  deliver_tag;
		logic [9:0]  deliver_len;
		logic [31:0] file_size;
		logic        last;
	} result_t;

	// One held early packet.
	typedef struct packed {
		logic [31:0] offset;
		logic [9:0]  len;
		logic [7:0]  tag;
	} entry_t;

	typedef struct packed {
		logic insert;
		logic shift;
	} cell_ctl_t;

	typedef struct packed {
		logic tok;
		logic hit;
		logic gt;
		logic le;
		logic dup;
	} cell_stat_t;

endpackage

[design/reorder_window_ack_receiver.sv]
// Every item except in-order DATA with held packets gives its one result in the cycle after
// its transfer, and busy stays low, so such items may follow each cycle.
// In-order DATA with held packets keeps busy high while the scan token walks the cell chain
// one cell per cycle, then while purging shifts the chain one cell per cycle for each packet
// purged. Results come one per cycle at most; the receiver cannot stall.
// Reset (arst_n low) clears the expected offset, held count, file size and session flag.
module reorder_window_ack_receiver #(
	parameter int WINDOW_DEPTH = rwar_pkg::DEF_WINDOW_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  rwar_pkg::item_t   item,
	output logic              busy,
	output logic              result_valid,
	output rwar_pkg::result_t result
);

	localparam int CntW = $clog2(WINDOW_DEPTH + 1);

	// Control states, one-hot.
	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_PURGE = 3'b100
	} state_t;

	state_t            state_q;
	logic [31:0]       expected_q;
	logic [CntW-1:0]   count_q;
	logic [9:0]        recorded_q;
	logic              over_q;
	logic              wave_tok_q;
	logic [31:0]       wave_exp_q;
	rwar_pkg::result_t pend_q;
	logic              pend_valid_q;
	rwar_pkg::result_t res_q;
	logic              res_valid_q;

	rwar_pkg::entry_t     cell_entry [WINDOW_DEPTH];
	rwar_pkg::cell_stat_t cell_stat  [WINDOW_DEPTH];
	logic [31:0]          cell_exp   [WINDOW_DEPTH];
	logic [WINDOW_DEPTH-1:0] cell_valid;
	logic [WINDOW_DEPTH-1:0] cell_tail;
	logic [WINDOW_DEPTH-1:0] cell_dup;
	logic [WINDOW_DEPTH-1:0] cell_tok;

	rwar_pkg::cell_ctl_t ctl;
	rwar_pkg::entry_t    new_entry;

	logic        accept;
	logic [9:0]  len_sat;
	logic [31:0] sum;
	logic [31:0] rec_ext;
	logic        do_insert;
	logic        go_scan;
	logic        set_expected;
	logic        set_over;
	logic        set_size;
	rwar_pkg::result_t acc_res;
	rwar_pkg::result_t hit_res;
	rwar_pkg::result_t pend_emit;
	logic        purge_now;
	logic [31:0] sel_exp;
	logic [7:0]  sel_tag;
	logic [9:0]  sel_len;
	logic        sel_hit;
	logic        wave_end;

	function automatic rwar_pkg::result_t mk_result(
		input logic [2:0]  kind,
		input logic [31:0] ack,
		input logic        dlv,
		input logic [7:0]  tag,
		input logic [9:0]  len,
		input logic [31:0] fsize,
		input logic        last
	);
		rwar_pkg::result_t r;
		r.kind        = kind;
		r.ack_number  = ack;
		r.deliver     = dlv;
		r.deliver_tag = dlv ? tag : 8'd0;
		r.deliver_len = dlv ? len : 10'd0;
		r.file_size   = fsize;
		r.last        = last;
		return r;
	endfunction

	// Cell chain. Cell i holds the i-th held packet in ascending offset order, and is
	// valid while i is below the held count.
	for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
		rwar_pkg::entry_t left_entry;
		rwar_pkg::entry_t right_entry;
		logic             left_gt;
		logic             left_le;
		logic             prev_tok;
		logic [31:0]      prev_exp;

		assign cell_valid[g] = CntW'(g) < count_q;
		assign cell_dup[g]   = cell_stat[g].dup;
		assign cell_tok[g]   = cell_stat[g].tok;

		if (g == 0) begin : g_head
			assign left_entry = '0;
			assign left_gt    = 1'b0;
			assign left_le    = 1'b1;
			assign prev_tok   = wave_tok_q;
			assign prev_exp   = wave_exp_q;
		end else begin : g_body
			assign left_entry = cell_entry[g-1];
			assign left_gt    = cell_stat[g-1].gt;
			assign left_le    = cell_stat[g-1].le;
			assign prev_tok   = cell_stat[g-1].tok;
			assign prev_exp   = cell_exp[g-1];
		end

		if (g == WINDOW_DEPTH - 1) begin : g_end
			assign right_entry  = '0;
			assign cell_tail[g] = cell_valid[g];
		end else begin : g_mid
			assign right_entry  = cell_entry[g+1];
			assign cell_tail[g] = cell_valid[g] && !cell_valid[g+1];
		end

		rwar_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.valid       (cell_valid[g]),
			.ctl         (ctl),
			.new_entry   (new_entry),
			.left_entry  (left_entry),
			.left_gt     (left_gt),
			.left_le     (left_le),
			.right_entry (right_entry),
			.prev_tok    (prev_tok),
			.prev_exp    (prev_exp),
			.entry       (cell_entry[g]),
			.stat        (cell_stat[g]),
			.run_exp     (cell_exp[g])
		);
	end

	assign busy         = (state_q != ST_IDLE);
	assign accept       = start && (state_q == ST_IDLE);
	assign result       = res_q;
	assign result_valid = res_valid_q;

	// Oversized data lengths saturate to the largest legal payload.
	assign len_sat = (32'(item.payload_len) > 32'(rwar_pkg::MAX_PAYLOAD)) ?
		10'(rwar_pkg::MAX_PAYLOAD) : item.payload_len;
	assign sum     = item.seq_offset + 32'(len_sat);
	assign rec_ext = 32'(recorded_q);

	assign new_entry = '{offset: item.seq_offset, len: len_sat, tag: item.buffer_tag};
	assign ctl.insert = accept && do_insert;
	assign ctl.shift  = (state_q == ST_PURGE) && purge_now;

	// Purge drops the leading held packets that the new expected offset has passed.
	assign purge_now = (count_q != '0) && (cell_entry[0].offset <= expected_q);

	// Decode of one accepted item.
	always_comb begin
		acc_res = mk_result(rwar_pkg::KIND_UNEXP, expected_q, 1'b0, 8'd0, 10'd0,
			rec_ext, 1'b1);
		do_insert    = 1'b0;
		go_scan      = 1'b0;
		set_expected = 1'b0;
		set_over     = 1'b0;
		set_size     = 1'b0;
		if (over_q) begin
			acc_res.kind = rwar_pkg::KIND_IGNORED;
		end else begin
			unique case (item.command)
				rwar_pkg::CMD_DATA: begin
					priority if (item.seq_offset == expected_q) begin
						acc_res = mk_result(rwar_pkg::KIND_ACK, sum, 1'b1, item.buffer_tag,
							len_sat, rec_ext, 1'b1);
						if (count_q == '0) begin
							set_expected = 1'b1;
						end else begin
							go_scan = 1'b1;
						end
					end else if (item.seq_offset < expected_q || (|cell_dup)) begin
						// Old or already held: re-ACK only.
						acc_res = mk_result(rwar_pkg::KIND_ACK, sum, 1'b0, 8'd0, 10'd0,
							rec_ext, 1'b1);
					end else if (32'(count_q) >= 32'(WINDOW_DEPTH)) begin
						acc_res.kind = rwar_pkg::KIND_FULL;
					end else begin
						do_insert = 1'b1;
						acc_res = mk_result(rwar_pkg::KIND_ACK, sum, 1'b0, 8'd0, 10'd0,
							rec_ext, 1'b1);
					end
				end
				rwar_pkg::CMD_FIN: begin
					set_size = 1'b1;
					set_over = 1'b1;
					acc_res = mk_result(rwar_pkg::KIND_FIN_ACK, item.seq_offset, 1'b0, 8'd0,
						10'd0, 32'(item.payload_len), 1'b1);
				end
				rwar_pkg::CMD_BAD: begin
					set_over = 1'b1;
					acc_res.kind = rwar_pkg::KIND_MISSING;
				end
				rwar_pkg::CMD_MSG: begin
					set_size = 1'b1;
					acc_res.kind      = rwar_pkg::KIND_SIZE;
					acc_res.file_size = 32'(item.payload_len);
				end
				default: begin
					acc_res.kind = rwar_pkg::KIND_UNEXP;
				end
			endcase
		end
	end

	// At most one cell holds the scan token, so its outputs are picked by an OR mux.
	always_comb begin
		sel_exp  = '0;
		sel_tag  = '0;
		sel_len  = '0;
		sel_hit  = 1'b0;
		wave_end = 1'b0;
		for (int i = 0; i < WINDOW_DEPTH; i++) begin
			if (cell_stat[i].tok) begin
				sel_exp  = sel_exp | cell_exp[i];
				sel_tag  = sel_tag | cell_entry[i].tag;
				sel_len  = sel_len | cell_entry[i].len;
				sel_hit  = sel_hit | cell_stat[i].hit;
				wave_end = wave_end | cell_tail[i];
			end
		end
	end

	assign hit_res = mk_result(rwar_pkg::KIND_ACK, sel_exp, 1'b1, sel_tag, sel_len,
		rec_ext, 1'b0);

	// The pending result goes out once the next one is known, so the final one can
	// carry the last flag.
	always_comb begin
		pend_emit      = pend_q;
		pend_emit.last = (state_q == ST_PURGE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			expected_q   <= '0;
			count_q      <= '0;
			recorded_q   <= '0;
			over_q       <= 1'b0;
			wave_tok_q   <= 1'b0;
			pend_valid_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			wave_tok_q  <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (go_scan) begin
							state_q      <= ST_SCAN;
							pend_valid_q <= 1'b1;
							wave_tok_q   <= 1'b1;
						end else begin
							res_valid_q <= 1'b1;
						end
						if (set_expected) begin
							expected_q <= sum;
						end
						if (set_over) begin
							over_q <= 1'b1;
						end
						if (set_size) begin
							recorded_q <= item.payload_len;
						end
						if (do_insert) begin
							count_q <= count_q + CntW'(1);
						end
					end
				end
				ST_SCAN: begin
					if (sel_hit) begin
						res_valid_q <= 1'b1;
					end
					if (wave_end) begin
						expected_q <= sel_exp;
						state_q    <= ST_PURGE;
					end
				end
				ST_PURGE: begin
					if (pend_valid_q) begin
						res_valid_q  <= 1'b1;
						pend_valid_q <= 1'b0;
					end
					if (purge_now) begin
						count_q <= count_q - CntW'(1);
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			wave_exp_q <= sum;
			if (go_scan) begin
				pend_q <= acc_res;
			end else begin
				res_q <= acc_res;
			end
		end else if (state_q == ST_SCAN && sel_hit) begin
			res_q  <= pend_emit;
			pend_q <= hit_res;
		end else if (state_q == ST_PURGE && pend_valid_q) begin
			res_q <= pend_emit;
		end
	end

	// The held count never exceeds the number of cells.
	assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= 32'(WINDOW_DEPTH))
		else $error("held count beyond window depth");

	// The scan token is never in two cells at once.
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cell_tok))
		else $error("more than one scan token in the cell chain");

	// While scanning there is always a result waiting for its successor.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> pend_valid_q)
		else $error("scan without a pending result");

	// An item that needs no scan shows its result in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !go_scan) |=> (result_valid && result.last))
		else $error("single result missing after transfer");

	// Fields of a result that releases nothing are zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.deliver) |->
			(result.deliver_tag == 8'd0 && result.deliver_len == 10'd0))
		else $error("delivery fields set on a result that delivers nothing");

endmodule

[design/rwar_cell.sv]
// One cell of the held-packet chain: stores one early packet and runs one step of the
// in-order scan wave. Depends on rwar_pkg for the entry, control and status types.
module rwar_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid,
	input  rwar_pkg::cell_ctl_t ctl,
	input  rwar_pkg::entry_t    new_entry,
	input  rwar_pkg::entry_t    left_entry,
	input  logic                left_gt,
	input  logic                left_le,
	input  rwar_pkg::entry_t    right_entry,
	input  logic                prev_tok,
	input  logic [31:0]         prev_exp,
	output rwar_pkg::entry_t    entry,
	output rwar_pkg::cell_stat_t stat,
	output logic [31:0]         run_exp
);

	rwar_pkg::entry_t entry_q;
	logic             tok_q;
	logic             hit_q;
	logic [31:0]      exp_q;
	logic             gt;
	logic             le;
	logic             dup;
	logic             hit;
	logic [31:0]      exp_nxt;

	assign gt  = valid && (entry_q.offset > new_entry.offset);
	assign le  = valid && (entry_q.offset < new_entry.offset);
	assign dup = valid && (entry_q.offset == new_entry.offset);

	// The scan token carries the running expected offset one cell per cycle.
	assign hit     = prev_tok && valid && (entry_q.offset == prev_exp);
	assign exp_nxt = hit ? prev_exp + 32'(entry_q.len) : prev_exp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			tok_q <= prev_tok && valid;
			hit_q <= hit;
		end
	end

	// Sorted insert moves larger entries one cell to the right; purge moves all left.
	always_ff @(posedge clk) begin
		exp_q <= exp_nxt;
		if (ctl.insert) begin
			if (left_gt) begin
				entry_q <= left_entry;
			end else if (left_le && !le) begin
				entry_q <= new_entry;
			end
		end else if (ctl.shift) begin
			entry_q <= right_entry;
		end
	end

	assign entry   = entry_q;
	assign run_exp = exp_q;
	assign stat    = '{tok: tok_q, hit: hit_q, gt: gt, le: le, dup: dup};

endmodule
